/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BZC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BZC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bzc_pkg.sv */
// types, constants and helper functions of the commutation sequencer
package bzc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BLANK = 2'd1,
        PH_WATCH = 2'd2,
        PH_PEND  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        OP_ENABLE  = 2'd0,
        OP_TIMER   = 2'd1,
        OP_CROSS   = 2'd2,
        OP_DISABLE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_BLANK_PCT  = 3'd0,
        CFG_DEADBAND   = 3'd1,
        CFG_MIN_STEP   = 3'd2,
        CFG_MISS_LIMIT = 3'd3,
        CFG_STEP_TABLE = 3'd4
    } cfg_idx_t;

    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 112;

    localparam logic [6:0]  BLANK_PCT_RST  = 7'd15;
    localparam logic [11:0] DEADBAND_RST   = 12'd20;
    localparam logic [31:0] MIN_STEP_RST   = 32'd100;
    localparam logic [7:0]  MISS_LIMIT_RST = 8'd3;
    localparam logic [17:0] STEP_TABLE_RST = 18'd21766;

    localparam logic [11:0] THRESH_MAX = 12'd4095;
    localparam logic [32:0] BLANK_MIN  = 33'd100;
    localparam logic [31:0] DELAY_MIN  = 32'd10;
    localparam logic [7:0]  MISS_SAT   = 8'd255;
    localparam logic [15:0] GOOD_SAT   = 16'hFFFF;
    localparam logic [2:0]  LAST_STEP  = 3'd5;

    // ceil(2^35/25) for a 30-bit dividend, ceil(2^17/25) for a 12-bit dividend
    localparam logic [30:0] RECIP25_BIG   = 31'd1374389535;
    localparam logic [12:0] RECIP25_SMALL = 13'd5243;
    localparam logic [31:0] HUNDRED       = 32'd100;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  step;
        logic        load;
        logic        blank_sel;
        logic [32:0] ticks;
        logic        stop;
        logic [1:0]  flt;
        logic [11:0] thr;
        logic        rising;
        logic        arm;
        logic        fallback;
        logic [31:0] period;
        logic [15:0] good;
    } res_t;

    function automatic logic [2:0] entry_of(input logic [17:0] tbl, input logic [2:0] s);
        logic [2:0] e;
        unique case (s)
            3'd0:    e = tbl[2:0];
            3'd1:    e = tbl[5:3];
            3'd2:    e = tbl[8:6];
            3'd3:    e = tbl[11:9];
            3'd4:    e = tbl[14:12];
            3'd5:    e = tbl[17:15];
            3'd6:    e = tbl[2:0];
            default: e = tbl[5:3];
        endcase
        return e;
    endfunction

    function automatic logic [1:0] float_of(input logic [2:0] e);
        return (e[1:0] == 2'd3) ? 2'd2 : e[1:0];
    endfunction

    function automatic logic [2:0] step_inc(input logic [2:0] s);
        return (s >= LAST_STEP) ? 3'd0 : s + 3'd1;
    endfunction

endpackage

/* hdl/bzc_pipe.sv */
// result pipeline: blanking delay arithmetic and output register with backpressure
module bzc_pipe import bzc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  res_t                in_res,
    input  logic [6:0]          blank_pct,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic adv1, adv2, adv3, adv4, advo;
    res_t res1_reg, res2_reg, res3_reg, res4_reg, out_reg, out_next;

    logic [60:0] prod_reg, prod_next;
    logic [25:0] q_reg, q_next;
    logic [6:0]  r_reg, r_next;
    logic [31:0] r_full;
    logic [32:0] bq_reg, bq_next;
    logic [13:0] br_reg, br_next;
    logic [24:0] small_prod;
    logic [32:0] blank_sum, blank_fin;

    assign advo     = !vo_reg || m_tready;
    assign adv4     = !v4_reg || advo;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // period*pct/100 = pct*(period/100) + pct*(period%100)/100
    assign prod_next  = 61'(res1_reg.period[31:2]) * 61'(RECIP25_BIG);
    assign q_next     = prod_reg[60:35];
    assign r_full     = res2_reg.period - 32'(q_next) * HUNDRED;
    assign r_next     = r_full[6:0];
    assign bq_next    = 33'(q_reg) * 33'(blank_pct);
    assign br_next    = 14'(r_reg) * 14'(blank_pct);
    assign small_prod = 25'(br_reg[13:2]) * 25'(RECIP25_SMALL);
    assign blank_sum  = bq_reg + 33'(small_prod[24:17]);
    assign blank_fin  = (blank_sum < BLANK_MIN) ? BLANK_MIN : blank_sum;

    always_comb begin
        out_next = res4_reg;
        if (res4_reg.blank_sel) begin
            out_next.ticks = blank_fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (advo) vo_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            res1_reg <= in_res;
        end
        if (adv2) begin
            res2_reg <= res1_reg;
            prod_reg <= prod_next;
        end
        if (adv3) begin
            res3_reg <= res2_reg;
            q_reg    <= q_next;
            r_reg    <= r_next;
        end
        if (adv4) begin
            res4_reg <= res3_reg;
            bq_reg   <= bq_next;
            br_reg   <= br_next;
        end
        if (advo) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {7'd0, out_reg.good, out_reg.period, out_reg.fallback, out_reg.arm,
                       out_reg.rising, out_reg.thr, out_reg.flt, out_reg.stop,
                       out_reg.ticks, out_reg.load, out_reg.step, out_reg.phase};

endmodule

/* hdl/bemf_zero_cross_commutation_sequencer.sv */
// top level of the sensorless six-step commutation sequencer
//
// Events enter on the s_ channel: s_tuser carries the event code (enable,
// timer expired, comparator crossing, disable) and s_tdata the timestamp,
// zero-crossing threshold, seed period and start step. Every accepted
// request yields exactly one result on the m_ channel with the phase, step,
// one-shot timer command, comparator setup, filtered period and good count.
// The sequencer state is updated at the edge that accepts the request, so a
// new event may follow in the very next cycle: throughput is one request
// per clock while s_tready is high. A result passes the pipeline stages and
// the output register before m_tvalid rises; the blanking-delay path sets the
// depth, dividing period*percent by 100 with two reciprocal multiplies.
// When the receiver stalls, results collect in the pipeline stages and
// s_tready drops only once all of them are full. Registers are written on
// the cfg_ channel, which is always ready; write them only while idle.
// Synchronous active-low reset puts the sequencer in idle with all counters,
// period and threshold at zero and the registers at their default values.
module bemf_zero_cross_commutation_sequencer import bzc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // timestamp[31:0], zc_threshold[43:32], seed_period[75:44], start_step[78:76]
    input  logic [S_DATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // phase_now[1:0], current_step_out[4:2], timer_load[5], timer_ticks[38:6],
    // timer_stop[39], float_phase[41:40], cmp_threshold[53:42], cmp_rising[54],
    // cmp_arm[55], fallback[56], period_out[88:57], good_count_out[104:89]
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    logic [6:0]  blank_pct_reg;
    logic [11:0] deadband_reg;
    logic [31:0] min_step_reg;
    logic [7:0]  miss_limit_reg;
    logic [17:0] step_table_reg;

    phase_t      phase_reg, phase_next;
    logic [2:0]  step_reg, step_next;
    logic [31:0] period_reg, period_next;
    logic [31:0] last_cross_reg, last_cross_next;
    logic [15:0] good_reg, good_next;
    logic [7:0]  miss_reg, miss_next;
    logic [11:0] thr_hold_reg, thr_hold_next;

    logic        acc;
    op_t         op;
    logic [31:0] ts;
    logic [11:0] zc;
    logic [31:0] seed;
    logic [2:0]  st;
    logic [2:0]  st_wrap, step_cmt, ent_cmt, ent_now;
    logic [12:0] thr_sum;
    logic [11:0] thr_cmt;
    logic [7:0]  miss_inc;
    logic [15:0] good_dec, good_inc;
    logic [31:0] interval, np, np_clamp, half;
    logic [33:0] np_sum;
    logic [31:0] delay;
    logic        do_cmt;
    res_t        res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_pct_reg  <= BLANK_PCT_RST;
            deadband_reg   <= DEADBAND_RST;
            min_step_reg   <= MIN_STEP_RST;
            miss_limit_reg <= MISS_LIMIT_RST;
            step_table_reg <= STEP_TABLE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BLANK_PCT:  blank_pct_reg  <= cfg_data[6:0];
                CFG_DEADBAND:   deadband_reg   <= cfg_data[11:0];
                CFG_MIN_STEP:   min_step_reg   <= cfg_data;
                CFG_MISS_LIMIT: miss_limit_reg <= cfg_data[7:0];
                CFG_STEP_TABLE: step_table_reg <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    assign acc  = s_tvalid && s_tready;
    assign op   = op_t'(s_tuser);
    assign ts   = s_tdata[31:0];
    assign zc   = s_tdata[43:32];
    assign seed = s_tdata[75:44];
    assign st   = s_tdata[78:76];

    assign st_wrap  = (st > LAST_STEP) ? st - 3'd6 : st;
    assign step_cmt = (op == OP_ENABLE) ? st_wrap : step_inc(step_reg);
    assign ent_cmt  = entry_of(step_table_reg, step_cmt);
    assign thr_sum  = {1'b0, zc} + {1'b0, deadband_reg};

    // rising edge raises the threshold, falling edge lowers it
    always_comb begin
        if (ent_cmt[2]) begin
            thr_cmt = (thr_sum < {1'b0, THRESH_MAX}) ? thr_sum[11:0] : THRESH_MAX;
        end else begin
            thr_cmt = (zc > deadband_reg) ? zc - deadband_reg : 12'd0;
        end
    end

    assign miss_inc = (miss_reg < MISS_SAT) ? miss_reg + 8'd1 : miss_reg;
    assign good_dec = (good_reg != 16'd0) ? good_reg - 16'd1 : good_reg;
    assign good_inc = (good_reg < GOOD_SAT) ? good_reg + 16'd1 : good_reg;

    // filtered period (3*old + interval)/4
    assign interval = ts - last_cross_reg;
    assign np_sum   = {2'b00, period_reg} + {1'b0, period_reg, 1'b0} + {2'b00, interval};
    assign np       = np_sum[33:2];
    assign np_clamp = (np < min_step_reg) ? min_step_reg : np;
    assign half     = {1'b0, np_clamp[31:1]};
    assign delay    = (half < DELAY_MIN) ? DELAY_MIN : half;

    always_comb begin
        phase_next      = phase_reg;
        step_next       = step_reg;
        period_next     = period_reg;
        last_cross_next = last_cross_reg;
        good_next       = good_reg;
        miss_next       = miss_reg;
        thr_hold_next   = thr_hold_reg;
        do_cmt          = 1'b0;
        res             = '0;
        if (acc) begin
            unique case (op)
                OP_ENABLE: begin
                    good_next       = 16'd0;
                    miss_next       = 8'd0;
                    period_next     = seed;
                    last_cross_next = ts;
                    step_next       = st_wrap;
                    do_cmt          = 1'b1;
                end
                OP_TIMER: begin
                    unique case (phase_reg)
                        PH_BLANK: begin
                            phase_next = PH_WATCH;
                            res.load   = 1'b1;
                            res.ticks  = {period_reg, 1'b0};
                        end
                        PH_WATCH: begin
                            miss_next = miss_inc;
                            good_next = good_dec;
                            if (miss_inc >= miss_limit_reg) begin
                                phase_next   = PH_IDLE;
                                res.stop     = 1'b1;
                                res.fallback = 1'b1;
                            end else begin
                                step_next = step_cmt;
                                do_cmt    = 1'b1;
                            end
                        end
                        PH_PEND: begin
                            step_next = step_cmt;
                            do_cmt    = 1'b1;
                        end
                        PH_IDLE: ;
                    endcase
                end
                OP_CROSS: begin
                    if (phase_reg == PH_WATCH) begin
                        period_next     = np_clamp;
                        last_cross_next = ts;
                        good_next       = good_inc;
                        miss_next       = 8'd0;
                        phase_next      = PH_PEND;
                        res.stop        = 1'b1;
                        res.load        = 1'b1;
                        res.ticks       = {1'b0, delay};
                    end
                end
                OP_DISABLE: begin
                    phase_next   = PH_IDLE;
                    res.stop     = 1'b1;
                    res.fallback = 1'b1;
                end
            endcase
            if (do_cmt) begin
                thr_hold_next = thr_cmt;
                phase_next    = PH_BLANK;
                res.load      = 1'b1;
                res.blank_sel = 1'b1;
            end
        end
        res.phase  = phase_next;
        res.step   = step_next;
        res.flt    = float_of(ent_now);
        res.rising = ent_now[2];
        res.thr    = thr_hold_next;
        res.arm    = (phase_next == PH_WATCH);
        res.period = period_next;
        res.good   = good_next;
    end

    assign ent_now = entry_of(step_table_reg, step_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            step_reg       <= 3'd0;
            period_reg     <= 32'd0;
            last_cross_reg <= 32'd0;
            good_reg       <= 16'd0;
            miss_reg       <= 8'd0;
            thr_hold_reg   <= 12'd0;
        end else begin
            phase_reg      <= phase_next;
            step_reg       <= step_next;
            period_reg     <= period_next;
            last_cross_reg <= last_cross_next;
            good_reg       <= good_next;
            miss_reg       <= miss_next;
            thr_hold_reg   <= thr_hold_next;
        end
    end

    bzc_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (acc),
        .in_ready  (s_tready),
        .in_res    (res),
        .blank_pct (blank_pct_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* hdl/bzc_checker.sv */
// port-level checker for the commutation sequencer and its bind
`include "assert_macros.svh"

module bzc_checker import bzc_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    `BZC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `BZC_ASSERT_IMP(a_stall_only_when_full, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stalled while output free")
    `BZC_ASSERT_IMP(a_arm_watch, aclk, aresetn, m_tvalid, m_tdata[55] == (m_tdata[1:0] == PH_WATCH), "comparator arm disagrees with phase")
    `BZC_ASSERT_IMP(a_fallback_idle, aclk, aresetn, m_tvalid && m_tdata[56], m_tdata[1:0] == PH_IDLE && m_tdata[39], "fallback without idle and timer stop")
    `BZC_ASSERT_IMP(a_blank_min, aclk, aresetn, m_tvalid && m_tdata[5] && m_tdata[1:0] == PH_BLANK, m_tdata[38:6] >= BLANK_MIN, "blanking delay below minimum")

endmodule

bind bemf_zero_cross_commutation_sequencer bzc_checker u_bzc_checker (.*);
